### sv/assert_macros.svh
// Assertion macros shared by the palette gradient RTL.
// Plain text macros; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PGT_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define PGT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("next-cycle implication failed");

`endif

### sv/pgt_pkg.sv
// Package for the palette gradient table: sizes, codes, sequencer states
// and the divider result bundle. No dependencies.
`default_nettype none

package pgt_pkg;

  localparam int MAX_COLORS    = 64;
  localparam int TABLE_ENTRIES = 256;

  localparam int SLOT_W    = 6;   // entry_slot field
  localparam int CNT_W     = 7;   // palette_count register
  localparam int IDX_IN_W  = 9;   // table_index field
  localparam int COLOR_W   = 24;
  localparam int CH_W      = 8;
  localparam int IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int N_W       = $clog2(2 * MAX_COLORS + 1);
  localparam int SEG_W     = $clog2(2 * MAX_COLORS);
  localparam int PROD_W    = IDX_W + 1 + N_W;
  localparam int BLEND_W   = CH_W + IDX_W + 1;
  localparam int DIV_CNT_W = $clog2(IDX_W + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIPES_ON    = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG,
    ST_DIV,
    ST_ADDR,
    ST_FETCH,
    ST_BLEND
  } pgt_state_e;

  // Step start position, floor(seg * TABLE_ENTRIES / n).
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] quot;
  } pgt_div_res_t;

endpackage

`default_nettype wire

### sv/pgt_if.sv
// Handshake channels of the palette gradient table: request and response.
// Depends on pgt_pkg.
`default_nettype none

interface pgt_req_if;
  import pgt_pkg::*;
  logic                valid;
  logic                ready;
  logic                func;
  logic [SLOT_W-1:0]   entry_slot;
  logic [COLOR_W-1:0]  rgb_value;
  logic [IDX_IN_W-1:0] table_index;

  modport source (output valid, func, entry_slot, rgb_value, table_index, input ready);
  modport sink   (input valid, func, entry_slot, rgb_value, table_index, output ready);
endinterface

interface pgt_rsp_if;
  import pgt_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

### sv/pgt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### sv/pgt_div.sv
// Iterative restoring divider: floor(seg * TABLE_ENTRIES / n), one quotient
// bit per cycle. Depends on pgt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pgt_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [pgt_pkg::SEG_W-1:0] seg_i,
  input  wire logic [pgt_pkg::N_W-1:0]   n_i,
  output pgt_pkg::pgt_div_res_t          res_o
);
  import pgt_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [N_W-1:0]       rem_q, rem_d;
  logic [N_W-1:0]       dsr_q, dsr_d;
  logic [IDX_W-1:0]     quot_q, quot_d;
  logic                 done_q, done_d;
  logic [N_W-1:0]       rem_shl;
  logic                 fits;

  // Dividend low bits are all zero, so each step only shifts in a zero.
  assign rem_shl = {rem_q[N_W-2:0], 1'b0};
  assign fits    = rem_shl >= dsr_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quot_d = quot_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(IDX_W);
      rem_d  = N_W'(seg_i);
      dsr_d  = n_i;
    end else if (busy_q) begin
      rem_d  = fits ? rem_shl - dsr_q : rem_shl;
      quot_d = {quot_q[IDX_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    quot_q <= quot_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;

  `PGT_ASSERT_IMPLY(a_start_when_idle, clk_i, rst_ni, start_i, !busy_q)
  `PGT_ASSERT_IMPLY(a_rem_below_divisor, clk_i, rst_ni, busy_q, rem_q < dsr_q)

endmodule

`default_nettype wire

### sv/pgt_blend.sv
// Three-channel linear blend of a start and end color by weight w out of
// TABLE_ENTRIES, rounded half up. Depends on pgt_pkg.
`default_nettype none

module pgt_blend (
  input  wire logic [pgt_pkg::COLOR_W-1:0] sc_i,
  input  wire logic [pgt_pkg::COLOR_W-1:0] ec_i,
  input  wire logic [pgt_pkg::IDX_W-1:0]   w_i,
  output logic      [pgt_pkg::COLOR_W-1:0] color_o
);
  import pgt_pkg::*;

  logic [IDX_W:0] inv_w;

  assign inv_w = (IDX_W + 1)'(TABLE_ENTRIES) - {1'b0, w_i};

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [BLEND_W-1:0] sum;
    assign sum = BLEND_W'(sc_i[c*CH_W +: CH_W]) * BLEND_W'(inv_w)
               + BLEND_W'(ec_i[c*CH_W +: CH_W]) * BLEND_W'(w_i)
               + BLEND_W'(TABLE_ENTRIES / 2);
    assign color_o[c*CH_W +: CH_W] = sum[IDX_W +: CH_W];
  end

endmodule

`default_nettype wire

### sv/palette_gradient_table.sv
// Top level of the palette gradient table: sequencer, config registers,
// palette RAM, divider, blend and output register.
// Depends on pgt_pkg, pgt_if, pgt_ram, pgt_div, pgt_blend, assert_macros.svh.
//
//   channel | dir | carries                                      | handshake
//   --------+-----+----------------------------------------------+-----------
//   req_i   | in  | func, entry_slot, rgb_value, table_index     | valid/ready
//   rsp_o   | out | red, green, blue                             | valid/ready
//   cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i              | write only
//
// A load request writes the palette RAM in its accept cycle and the block
// is ready again in the next cycle. A lookup goes from accept to a loaded
// response register via ST_SEG for the segment product, ST_DIV for the
// one-bit-per-cycle divider that finds the segment start, and ST_ADDR,
// ST_FETCH, ST_BLEND for the two palette RAM reads on its single port and blend.
// Reset (rst_ni, async, active low) clears the sequencer, the response
// valid and the config registers to count 1, stripes off; the palette RAM
// is not cleared. A stalled response holds in the output register while
// the next request is accepted; the blend step waits only if that register
// is still full when the next result is ready.
`default_nettype none
`include "assert_macros.svh"

module palette_gradient_table (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pgt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [pgt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pgt_req_if.sink                             req_i,
  pgt_rsp_if.source                           rsp_o
);
  import pgt_pkg::*;

  pgt_state_e state_q, state_d;

  // Configuration.
  logic [CNT_W-1:0] cfg_count_q;
  logic             cfg_stripes_q;
  logic [CNT_W-1:0] count_eff;
  logic [N_W-1:0]   n_eff;

  // Per-lookup working registers.
  logic [IDX_W-1:0] idx_q;
  logic [N_W-1:0]   n_q;
  logic             stripes_q;
  logic [SEG_W-1:0] seg_q, seg_d;
  logic [IDX_W-1:0] w_q, w_d;
  logic [SLOT_W-1:0] ec_slot_q;
  logic             sc_black_q, ec_black_q;
  logic [COLOR_W-1:0] sc_q;

  // Response register.
  logic               out_valid_q, out_valid_d;
  logic [COLOR_W-1:0] out_color_q;

  // Control from the sequencer.
  logic req_fire, rsp_fire;
  logic take_lookup, seg_en, addr_en, fetch_en, out_load;
  logic ram_we;
  logic [SLOT_W-1:0] ram_raddr;
  logic [COLOR_W-1:0] ram_rdata;

  // Segment and slot arithmetic.
  logic [PROD_W-1:0] seg_prod;
  logic [IDX_W-1:0]  idx_diff;
  logic [2*IDX_W-1:0] w_prod;
  logic [N_W-1:0]    seg_next;
  logic [SEG_W-1:0]  ec_step;
  logic [SLOT_W-1:0] sc_slot, ec_slot;
  logic [COLOR_W-1:0] blend_sc, blend_ec, blend_color;

  pgt_div_res_t div_res;

  function automatic logic [SLOT_W-1:0] step_slot(logic [SEG_W-1:0] step, logic stripes);
    logic [SEG_W-1:0] s;
    s = stripes ? (step >> 1) : step;
    return s[SLOT_W-1:0];
  endfunction

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_fire = rsp_o.valid && rsp_o.ready;

  // Clamp the count to 1..MAX_COLORS and double it for stripes.
  always_comb begin
    if (cfg_count_q == '0) begin
      count_eff = CNT_W'(1);
    end else if (cfg_count_q > CNT_W'(MAX_COLORS)) begin
      count_eff = CNT_W'(MAX_COLORS);
    end else begin
      count_eff = cfg_count_q;
    end
    n_eff = cfg_stripes_q ? {count_eff, 1'b0} : {1'b0, count_eff};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q   <= CNT_W'(1);
      cfg_stripes_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PALETTE_COUNT: cfg_count_q   <= cfg_data_i[CNT_W-1:0];
        CFG_STRIPES_ON:    cfg_stripes_q <= cfg_data_i[0];
        default:           ;
      endcase
    end
  end

  // Segment: last step k with floor(k*T/n) <= idx, i.e. ((idx+1)*n - 1) / T.
  assign seg_prod = PROD_W'({1'b0, idx_q} + 1'b1) * PROD_W'(n_q) - 1'b1;
  assign seg_d    = seg_prod[IDX_W +: SEG_W];

  // Weight: n times the distance from the step start.
  assign idx_diff = idx_q - div_res.quot;
  assign w_prod   = (2 * IDX_W)'(n_q) * (2 * IDX_W)'(idx_diff);
  assign w_d      = w_prod[IDX_W-1:0];

  // End color is the next step, wrapping to step 0 after the last one.
  assign seg_next = N_W'(seg_q) + 1'b1;
  assign ec_step  = (seg_next == n_q) ? '0 : seg_next[SEG_W-1:0];
  assign sc_slot  = step_slot(seg_q, stripes_q);
  assign ec_slot  = step_slot(ec_step, stripes_q);

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    ram_we      = 1'b0;
    take_lookup = 1'b0;
    seg_en      = 1'b0;
    addr_en     = 1'b0;
    fetch_en    = 1'b0;
    out_load    = 1'b0;
    ram_raddr   = ec_slot_q;
    out_valid_d = out_valid_q && !rsp_fire;
    unique case (state_q)
      ST_IDLE: begin
        // Ready is high here, so valid alone marks an accepted request.
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          if (req_i.func == FUNC_LOAD) begin
            ram_we = 1'b1;
          end else begin
            take_lookup = 1'b1;
            state_d     = ST_SEG;
          end
        end
      end
      ST_SEG: begin
        seg_en  = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        // Issue the start color read; end color follows next cycle.
        addr_en   = 1'b1;
        ram_raddr = sc_slot;
        state_d   = ST_FETCH;
      end
      ST_FETCH: begin
        fetch_en = 1'b1;
        state_d  = ST_BLEND;
      end
      ST_BLEND: begin
        // Hold here while the previous response is still waiting.
        if (!out_valid_q || rsp_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take_lookup) begin
      idx_q     <= req_i.table_index[IDX_W-1:0];
      n_q       <= n_eff;
      stripes_q <= cfg_stripes_q;
    end
    if (seg_en) begin
      seg_q <= seg_d;
    end
    if (addr_en) begin
      w_q        <= w_d;
      ec_slot_q  <= ec_slot;
      sc_black_q <= stripes_q && seg_q[0];
      ec_black_q <= stripes_q && ec_step[0];
    end
    if (fetch_en) begin
      sc_q <= ram_rdata;
    end
    if (out_load) begin
      out_color_q <= blend_color;
    end
  end

  pgt_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (MAX_COLORS)
  ) u_palette_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (req_i.entry_slot),
    .wdata_i (req_i.rgb_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pgt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (seg_en),
    .seg_i   (seg_d),
    .n_i     (n_q),
    .res_o   (div_res)
  );

  // Black steps of stripes mode bypass the palette.
  assign blend_sc = sc_black_q ? '0 : sc_q;
  assign blend_ec = ec_black_q ? '0 : ram_rdata;

  pgt_blend u_blend (
    .sc_i    (blend_sc),
    .ec_i    (blend_ec),
    .w_i     (w_q),
    .color_o (blend_color)
  );

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.red   = out_color_q[2*CH_W +: CH_W];
  assign rsp_o.green = out_color_q[CH_W +: CH_W];
  assign rsp_o.blue  = out_color_q[0 +: CH_W];

  `PGT_ASSERT_NEXT(a_load_no_rsp, clk_i, rst_ni,
                   req_fire && req_i.func == FUNC_LOAD && !out_valid_q, !out_valid_q)
  `PGT_ASSERT_IMPLY(a_div_done_in_div, clk_i, rst_ni, div_res.done, state_q == ST_DIV)
  `PGT_ASSERT_NEXT(a_blend_free_loads, clk_i, rst_ni,
                   state_q == ST_BLEND && !out_valid_q, out_valid_q && state_q == ST_IDLE)

endmodule

`default_nettype wire
